FILE: hdl/hca_pkg.sv
package hca_pkg;

  localparam int unsigned ONE_Q15    = 32768;
  localparam int unsigned HUE_SECTOR = 3840;
  localparam int unsigned HUE_FULL   = 23040;
  // 32768 * 3840, denominator of q and t
  localparam int unsigned FULL_SCALE = 125829120;
  // ceil(2^23 / 15), exact for dividends below 2^23 / 7
  localparam int unsigned RECIP15    = 559241;
  localparam int unsigned DIV_STEPS  = 17;

  typedef enum logic [1:0] {
    MODE_HSV  = 2'd0,
    MODE_RGB  = 2'd1,
    MODE_ADJ  = 2'd2,
    MODE_PASS = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] in_c0;
    logic [15:0] in_c1;
    logic [15:0] in_c2;
    logic [15:0] in_alpha;
  } pix_in_t;

  typedef struct packed {
    logic [15:0] out_c0;
    logic [15:0] out_c1;
    logic [15:0] out_c2;
    logic [15:0] out_alpha;
  } pix_out_t;

  // travels alongside the two dividers
  typedef struct packed {
    mode_e       mode;
    logic [15:0] c0;     // raw, hue in hsv->rgb mode
    logic [15:0] c1;
    logic [15:0] c2;
    logic [15:0] alpha;
    logic [15:0] mx;
    logic        dzero;
    logic [1:0]  sector;
    logic        neg;
    logic [31:0] ap1;
  } div_side_t;

  // travels alongside the hsv->rgb pipe
  typedef struct packed {
    mode_e       mode;
    logic [15:0] d0;     // direct result for rgb->hsv and pass modes
    logic [15:0] d1;
    logic [15:0] d2;
    logic [15:0] alpha;
  } rgb_side_t;

  function automatic logic [15:0] sat_one(input logic [15:0] x);
    return (x > 16'(ONE_Q15)) ? 16'(ONE_Q15) : x;
  endfunction

endpackage

FILE: hdl/hca_div.sv
module hca_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [31:0]       dvd_a_i,
  input  logic [15:0]       dvs_a_i,
  input  logic [31:0]       dvd_b_i,
  input  logic [15:0]       dvs_b_i,
  input  hca_pkg::div_side_t side_i,
  output logic              valid_o,
  output logic [16:0]       quo_a_o,
  output logic [16:0]       quo_b_o,
  output hca_pkg::div_side_t side_o
);
  import hca_pkg::*;

  // {quotient bit, new remainder}
  function automatic logic [16:0] div_step(input logic [15:0] r, input logic b,
                                            input logic [15:0] d);
    logic [16:0] t;
    logic [16:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {1'b1, s[15:0]};
    end
    return {1'b0, t[15:0]};
  endfunction

  logic [15:0] ra_q [DIV_STEPS];
  logic [16:0] la_q [DIV_STEPS];
  logic [16:0] qa_q [DIV_STEPS];
  logic [15:0] da_q [DIV_STEPS];
  logic [15:0] rb_q [DIV_STEPS];
  logic [16:0] lb_q [DIV_STEPS];
  logic [16:0] qb_q [DIV_STEPS];
  logic [15:0] db_q [DIV_STEPS];
  div_side_t   side_q [DIV_STEPS];
  logic        vld_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
    logic [15:0] ra_p, rb_p, da_p, db_p;
    logic [16:0] la_p, lb_p, qa_p, qb_p;
    div_side_t   side_p;
    logic        vld_p;
    logic [16:0] sa, sb;

    if (j == 0) begin : g_first
      assign ra_p   = 16'(dvd_a_i[31:17]);
      assign la_p   = dvd_a_i[16:0];
      assign qa_p   = '0;
      assign da_p   = dvs_a_i;
      assign rb_p   = 16'(dvd_b_i[31:17]);
      assign lb_p   = dvd_b_i[16:0];
      assign qb_p   = '0;
      assign db_p   = dvs_b_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign ra_p   = ra_q[j-1];
      assign la_p   = la_q[j-1];
      assign qa_p   = qa_q[j-1];
      assign da_p   = da_q[j-1];
      assign rb_p   = rb_q[j-1];
      assign lb_p   = lb_q[j-1];
      assign qb_p   = qb_q[j-1];
      assign db_p   = db_q[j-1];
      assign side_p = side_q[j-1];
      assign vld_p  = vld_q[j-1];
    end

    assign sa = div_step(ra_p, la_p[16], da_p);
    assign sb = div_step(rb_p, lb_p[16], db_p);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[j]   <= sa[15:0];
        la_q[j]   <= {la_p[15:0], 1'b0};
        qa_q[j]   <= {qa_p[15:0], sa[16]};
        da_q[j]   <= da_p;
        rb_q[j]   <= sb[15:0];
        lb_q[j]   <= {lb_p[15:0], 1'b0};
        qb_q[j]   <= {qb_p[15:0], sb[16]};
        db_q[j]   <= db_p;
        side_q[j] <= side_p;
      end
    end
  end

  assign valid_o = vld_q[DIV_STEPS-1];
  assign quo_a_o = qa_q[DIV_STEPS-1];
  assign quo_b_o = qb_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];

endmodule

FILE: hdl/hca_rgb.sv
module hca_rgb (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [14:0]       h_i,
  input  logic [15:0]       s_i,
  input  logic [15:0]       v_i,
  input  hca_pkg::rgb_side_t side_i,
  output logic              valid_o,
  output hca_pkg::pix_out_t  data_o
);
  import hca_pkg::*;

  logic [5:0] vld_q;

  // R1: sector split
  logic [2:0]  i1_d;
  logic [11:0] f1_d;
  logic [2:0]  i1_q;
  logic [11:0] f1_q;
  logic [15:0] s1_q, v1_q, oms1_q;
  rgb_side_t   side1_q;

  always_comb begin
    i1_d = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (h_i >= 15'(k * HUE_SECTOR)) begin
        i1_d = 3'(k);
      end
    end
    f1_d = 12'(h_i - 15'(i1_d * 15'(HUE_SECTOR)));
  end

  // R2: products with s
  logic [27:0] sf2_q, sg2_q;
  logic [31:0] pp2_q;
  logic [2:0]  i2_q;
  logic [15:0] v2_q;
  logic        sz2_q;
  rgb_side_t   side2_q;

  // R3
  logic [26:0] xq3_q, xt3_q;
  logic [15:0] p3_q, v3_q;
  logic [2:0]  i3_q;
  logic        sz3_q;
  rgb_side_t   side3_q;

  // R4
  logic [42:0] mq4_q, mt4_q;
  logic [15:0] p4_q, v4_q;
  logic [2:0]  i4_q;
  logic        sz4_q;
  rgb_side_t   side4_q;

  // R5: divide by 15 through the reciprocal
  logic [39:0] rq5_q, rt5_q;
  logic [15:0] p5_q, v5_q;
  logic [2:0]  i5_q;
  logic        sz5_q;
  rgb_side_t   side5_q;

  // R6: select
  logic [15:0] q6, t6;
  pix_out_t    out_d, out_q;

  always_comb begin
    q6 = rq5_q[38:23];
    t6 = rt5_q[38:23];
    out_d.out_alpha = side5_q.alpha;
    if (side5_q.mode == MODE_HSV || side5_q.mode == MODE_PASS) begin
      out_d.out_c0 = side5_q.d0;
      out_d.out_c1 = side5_q.d1;
      out_d.out_c2 = side5_q.d2;
    end else if (sz5_q) begin
      out_d.out_c0 = v5_q;
      out_d.out_c1 = v5_q;
      out_d.out_c2 = v5_q;
    end else begin
      case (i5_q)
        3'd0: begin
          out_d.out_c0 = v5_q; out_d.out_c1 = t6;   out_d.out_c2 = p5_q;
        end
        3'd1: begin
          out_d.out_c0 = q6;   out_d.out_c1 = v5_q; out_d.out_c2 = p5_q;
        end
        3'd2: begin
          out_d.out_c0 = p5_q; out_d.out_c1 = v5_q; out_d.out_c2 = t6;
        end
        3'd3: begin
          out_d.out_c0 = p5_q; out_d.out_c1 = q6;   out_d.out_c2 = v5_q;
        end
        3'd4: begin
          out_d.out_c0 = t6;   out_d.out_c1 = p5_q; out_d.out_c2 = v5_q;
        end
        default: begin
          out_d.out_c0 = v5_q; out_d.out_c1 = p5_q; out_d.out_c2 = q6;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      i1_q    <= i1_d;
      f1_q    <= f1_d;
      s1_q    <= s_i;
      v1_q    <= v_i;
      oms1_q  <= 16'(17'(ONE_Q15) - {1'b0, s_i});
      side1_q <= side_i;

      sf2_q   <= 28'(s1_q) * 28'(f1_q);
      sg2_q   <= 28'(s1_q) * 28'(12'(HUE_SECTOR) - f1_q);
      pp2_q   <= 32'(v1_q) * 32'(oms1_q);
      i2_q    <= i1_q;
      v2_q    <= v1_q;
      sz2_q   <= (s1_q == '0);
      side2_q <= side1_q;

      xq3_q   <= 27'(28'(FULL_SCALE) - sf2_q);
      xt3_q   <= 27'(28'(FULL_SCALE) - sg2_q);
      p3_q    <= pp2_q[30:15];
      v3_q    <= v2_q;
      i3_q    <= i2_q;
      sz3_q   <= sz2_q;
      side3_q <= side2_q;

      mq4_q   <= 43'(v3_q) * 43'(xq3_q);
      mt4_q   <= 43'(v3_q) * 43'(xt3_q);
      p4_q    <= p3_q;
      v4_q    <= v3_q;
      i4_q    <= i3_q;
      sz4_q   <= sz3_q;
      side4_q <= side3_q;

      rq5_q   <= 40'(mq4_q[42:23]) * 40'(RECIP15);
      rt5_q   <= 40'(mt4_q[42:23]) * 40'(RECIP15);
      p5_q    <= p4_q;
      v5_q    <= v4_q;
      i5_q    <= i4_q;
      sz5_q   <= sz4_q;
      side5_q <= side4_q;

      out_q   <= out_d;
    end
  end

  assign valid_o = vld_q[5];
  assign data_o  = out_q;

endmodule

FILE: hdl/hsv_color_convert_adjust.sv
// Pixel color conversion, RGB->HSV, HSV->RGB and HSV adjust, plus clamped pass-through.
// 27 register stages; the 17-stage dual restoring divider sets the depth.
// Throughput: one pixel per clock while the output is not stalled.
// A stalled output freezes the whole pipeline.
// Reset clears all valid bits and loads the registers with zero offsets and unity gains.
module hsv_color_convert_adjust (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  hca_pkg::pix_in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output hca_pkg::pix_out_t out_data_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hca_pkg::*;

  localparam logic [2:0] REG_HUE_OFF = 3'd0;
  localparam logic [2:0] REG_SAT_OFF = 3'd1;
  localparam logic [2:0] REG_VAL_OFF = 3'd2;
  localparam logic [2:0] REG_A_SCALE = 3'd3;
  localparam logic [2:0] REG_A_GAIN  = 3'd4;

  logic        en;
  logic [15:0] hue_off_q, a_scale_q, a_gain_q;
  logic [16:0] sat_off_q, val_off_q;
  logic [2:0]  ridx;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign pready     = 1'b1;
  assign ridx       = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_off_q <= '0;
      sat_off_q <= '0;
      val_off_q <= '0;
      a_scale_q <= 16'(ONE_Q15);
      a_gain_q  <= 16'(ONE_Q15);
    end else if (psel && penable && pwrite && pready) begin
      case (ridx)
        REG_HUE_OFF: hue_off_q <= pwdata[15:0];
        REG_SAT_OFF: sat_off_q <= pwdata[16:0];
        REG_VAL_OFF: val_off_q <= pwdata[16:0];
        REG_A_SCALE: a_scale_q <= pwdata[15:0];
        REG_A_GAIN:  a_gain_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_HUE_OFF: prdata = 32'(hue_off_q);
      REG_SAT_OFF: prdata = 32'(sat_off_q);
      REG_VAL_OFF: prdata = 32'(val_off_q);
      REG_A_SCALE: prdata = 32'(a_scale_q);
      REG_A_GAIN:  prdata = 32'(a_gain_q);
      default:     prdata = '0;
    endcase
  end

  // S0: input register, clamping c1, c2 and alpha to one; c0 stays raw
  logic        v0_q;
  mode_e       mode0_q;
  logic [15:0] c0_0_q, c1_0_q, c2_0_q, a0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode0_q <= mode_e'(in_data_i.mode);
      c0_0_q  <= in_data_i.in_c0;
      c1_0_q  <= sat_one(in_data_i.in_c1);
      c2_0_q  <= sat_one(in_data_i.in_c2);
      a0_q    <= sat_one(in_data_i.in_alpha);
    end
  end

  // S1: max/min, numerator, divider operands, first alpha product
  logic [15:0] r0, mx, mn, dl, absn;
  logic [16:0] num;
  logic [1:0]  sect;
  logic        v1_q;
  logic [31:0] dvd_a_q, dvd_b_q;
  logic [15:0] dvs_a_q, dvs_b_q;
  div_side_t   side1_d, side1_q;

  always_comb begin
    r0 = sat_one(c0_0_q);
    mx = (r0 > c1_0_q) ? r0 : c1_0_q;
    mn = (r0 < c1_0_q) ? r0 : c1_0_q;
    if (c2_0_q > mx) mx = c2_0_q;
    if (c2_0_q < mn) mn = c2_0_q;
    dl = mx - mn;
    if (r0 >= mx) begin
      sect = 2'd0;
      num  = {1'b0, c1_0_q} - {1'b0, c2_0_q};
    end else if (c1_0_q >= mx) begin
      sect = 2'd1;
      num  = {1'b0, c2_0_q} - {1'b0, r0};
    end else begin
      sect = 2'd2;
      num  = {1'b0, r0} - {1'b0, c1_0_q};
    end
    absn = num[16] ? 16'(17'd0 - num) : num[15:0];
    side1_d.mode   = mode0_q;
    side1_d.c0     = c0_0_q;
    side1_d.c1     = c1_0_q;
    side1_d.c2     = c2_0_q;
    side1_d.alpha  = a0_q;
    side1_d.mx     = mx;
    side1_d.dzero  = (dl == '0);
    side1_d.sector = sect;
    side1_d.neg    = num[16];
    side1_d.ap1    = 32'(a0_q) * 32'(a_scale_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dvd_a_q <= {1'b0, dl, 15'd0};
      dvs_a_q <= mx;
      // |num| * 3840 = |num| * 4096 - |num| * 256
      dvd_b_q <= 32'({absn, 12'd0}) - 32'({absn, 8'd0});
      dvs_b_q <= dl;
      side1_q <= side1_d;
    end
  end

  logic        vd;
  logic [16:0] quo_a, quo_b;
  div_side_t   sided;

  hca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .dvd_a_i (dvd_a_q),
    .dvs_a_i (dvs_a_q),
    .dvd_b_i (dvd_b_q),
    .dvs_b_i (dvs_b_q),
    .side_i  (side1_q),
    .valid_o (vd),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .side_o  (sided)
  );

  // S2: hue assembly, second alpha product
  logic signed [16:0] hs;
  logic [14:0] h2_d;
  logic [15:0] s2_d;
  logic        v2_q;
  logic [14:0] h2_q;
  logic [15:0] s2_q;
  logic [47:0] ap2_q;
  div_side_t   side2_q;

  always_comb begin
    hs = signed'(17'(sided.sector) * 17'(2 * HUE_SECTOR));
    if (sided.neg) begin
      hs = hs - signed'({5'd0, quo_b[11:0]});
    end else begin
      hs = hs + signed'({5'd0, quo_b[11:0]});
    end
    if (hs < 0) hs = hs + 17'sd23040;
    h2_d = sided.dzero ? '0 : hs[14:0];
    s2_d = sided.dzero ? '0 : quo_a[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_q    <= h2_d;
      s2_q    <= s2_d;
      ap2_q   <= 48'(sided.ap1) * 48'(a_gain_q);
      side2_q <= sided;
    end
  end

  // S3: adjust and pick the hsv->rgb operands
  logic signed [17:0] hh, sa, va;
  logic [17:0] ash;
  logic [15:0] sc, vc, ac;
  logic        v3_q;
  logic [14:0] h3_q;
  logic [15:0] s3_q, v3v_q;
  rgb_side_t   rs_d, rs_q;

  always_comb begin
    hh = signed'({3'd0, h2_q}) + 18'(signed'(hue_off_q));
    if (hh < 0) hh = hh + 18'sd23040;
    if (hh < 0) hh = hh + 18'sd23040;
    if (hh >= 18'sd23040) hh = hh - 18'sd23040;
    if (hh >= 18'sd23040) hh = hh - 18'sd23040;
    sa = signed'({2'd0, s2_q}) + 18'(signed'(sat_off_q));
    va = signed'({2'd0, side2_q.mx}) + 18'(signed'(val_off_q));
    sc = (sa < 0) ? '0 : ((sa > 18'sd32768) ? 16'(ONE_Q15) : sa[15:0]);
    vc = (va < 0) ? '0 : ((va > 18'sd32768) ? 16'(ONE_Q15) : va[15:0]);
    ash = ap2_q[47:30];
    ac  = (ash > 18'(ONE_Q15)) ? 16'(ONE_Q15) : ash[15:0];

    rs_d.mode  = side2_q.mode;
    rs_d.alpha = (side2_q.mode == MODE_ADJ) ? ac : side2_q.alpha;
    if (side2_q.mode == MODE_HSV) begin
      rs_d.d0 = {1'b0, h2_q};
      rs_d.d1 = s2_q;
      rs_d.d2 = side2_q.mx;
    end else begin
      rs_d.d0 = sat_one(side2_q.c0);
      rs_d.d1 = side2_q.c1;
      rs_d.d2 = side2_q.c2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (side2_q.mode == MODE_ADJ) begin
        h3_q  <= hh[14:0];
        s3_q  <= sc;
        v3v_q <= vc;
      end else begin
        // hue of a full turn or more counts as zero
        h3_q  <= (side2_q.c0 >= 16'(HUE_FULL)) ? '0 : side2_q.c0[14:0];
        s3_q  <= side2_q.c1;
        v3v_q <= side2_q.c2;
      end
      rs_q <= rs_d;
    end
  end

  hca_rgb u_rgb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .h_i     (h3_q),
    .s_i     (s3_q),
    .v_i     (v3v_q),
    .side_i  (rs_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

FILE: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hca_pkg::*;

  localparam int LATENCY   = 27;
  localparam int MAX_CYCLES = 400000;

  // register indexes
  localparam logic [2:0] REG_HUE = 3'd0;
  localparam logic [2:0] REG_SAT = 3'd1;
  localparam logic [2:0] REG_VAL = 3'd2;
  localparam logic [2:0] REG_ASC = 3'd3;
  localparam logic [2:0] REG_AGN = 3'd4;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  pix_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  pix_out_t    out_data_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hsv_color_convert_adjust u_top (.*);

  always #5 clk_i = ~clk_i;

  // shadow of the configuration
  logic signed [15:0] hue_ofs;
  logic signed [16:0] sat_ofs, val_ofs;
  logic [15:0]        a_scale, a_gain;

  pix_out_t pix_expected_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_long = 1'b0;

  function automatic logic [15:0] clip_one(input logic [31:0] x);
    return (x > 32'd32768) ? 16'd32768 : x[15:0];
  endfunction

  function automatic void rgb2hsv(input int r, input int g, input int b,
                                  output int h, output int s, output int v);
    int mx, mn, delta, num, base;
    longint hh;
    mx = (r > g) ? r : g;
    mn = (r < g) ? r : g;
    if (b > mx) mx = b;
    if (b < mn) mn = b;
    v = mx;
    delta = mx - mn;
    if (delta == 0) begin
      h = 0; s = 0;
      return;
    end
    s = int'((longint'(delta) * 32768) / mx);
    if (r >= mx) begin
      base = 0; num = g - b;
    end else if (g >= mx) begin
      base = 2 * 3840; num = b - r;
    end else begin
      base = 4 * 3840; num = r - g;
    end
    hh = base + (longint'(num) * 3840) / delta;
    if (hh < 0) hh += 23040;
    h = int'(hh);
  endfunction

  function automatic void hsv2rgb(input int h, input int s, input int v,
                                  output int r, output int g, output int b);
    longint unsigned full;
    int sec, f, p, q, t;
    full = 64'd32768 * 3840;
    if (s == 0) begin
      r = v; g = v; b = v;
      return;
    end
    if (h >= 23040) h = 0;
    sec = h / 3840;
    f = h % 3840;
    p = int'((longint'(v) * (32768 - s)) >>> 15);
    q = int'((longint'(v) * (full - longint'(s) * f)) / full);
    t = int'((longint'(v) * (full - longint'(s) * (3840 - f))) / full);
    case (sec)
      0: begin r = v; g = t; b = p; end
      1: begin r = q; g = v; b = p; end
      2: begin r = p; g = v; b = t; end
      3: begin r = p; g = q; b = v; end
      4: begin r = t; g = p; b = v; end
      default: begin r = v; g = p; b = q; end
    endcase
  endfunction

  function automatic pix_out_t convert_pixel(input pix_in_t px);
    pix_out_t o;
    int c1, c2, a, h, s, v, r, g, b, hh;
    longint unsigned prod;
    c1 = clip_one(px.in_c1);
    c2 = clip_one(px.in_c2);
    a  = clip_one(px.in_alpha);
    r = 0; g = 0; b = 0;
    o.out_alpha = a[15:0];
    case (mode_e'(px.mode))
      MODE_HSV: rgb2hsv(clip_one(px.in_c0), c1, c2, r, g, b);
      MODE_RGB: hsv2rgb(px.in_c0, c1, c2, r, g, b);
      MODE_ADJ: begin
        rgb2hsv(clip_one(px.in_c0), c1, c2, h, s, v);
        hh = (h + hue_ofs) % 23040;
        if (hh < 0) hh += 23040;
        s = s + sat_ofs;
        s = (s < 0) ? 0 : (s > 32768) ? 32768 : s;
        v = v + val_ofs;
        v = (v < 0) ? 0 : (v > 32768) ? 32768 : v;
        prod = (longint'(a) * a_scale * a_gain) >> 30;
        o.out_alpha = (prod > 32768) ? 16'd32768 : prod[15:0];
        hsv2rgb(hh, s, v, r, g, b);
      end
      default: begin
        r = clip_one(px.in_c0); g = c1; b = c2;
      end
    endcase
    o.out_c0 = r[15:0];
    o.out_c1 = g[15:0];
    o.out_c2 = b[15:0];
    return o;
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_HUE: hue_ofs = val[15:0];
      REG_SAT: sat_ofs = val[16:0];
      REG_VAL: val_ofs = val[16:0];
      REG_ASC: a_scale = val[15:0];
      default: a_gain  = val[15:0];
    endcase
  endtask

  task automatic drain();
    while (pix_expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send_pixel(input pix_in_t px);
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    pix_expected_q.push_back(convert_pixel(px));
  endtask

  task automatic idle_sender(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic pix_in_t rand_pixel();
    pix_in_t px;
    px.mode = ($urandom_range(0, 19) == 0) ? MODE_PASS : 2'($urandom_range(0, 2));
    px.in_c0 = (px.mode == MODE_RGB && $urandom_range(0, 3) != 0) ?
               16'($urandom_range(0, 23039)) : rand_chan();
    px.in_c1 = rand_chan();
    px.in_c2 = rand_chan();
    px.in_alpha = rand_chan();
    // grey and two-equal-channel cases
    if ($urandom_range(0, 9) == 0) px.in_c1 = px.in_c0;
    if ($urandom_range(0, 14) == 0) px.in_c2 = px.in_c0;
    return px;
  endfunction

  typedef struct {
    pix_in_t  px;
    bit       known;
    pix_out_t res;
  } stim_row_t;

  stim_row_t stim_table[] = '{
    '{'{MODE_HSV, 16'd0, 16'd0, 16'd0, 16'd0}, 1, '{16'd0, 16'd0, 16'd0, 16'd0}},
    '{'{MODE_HSV, 16'd32768, 16'd0, 16'd0, 16'd32768}, 1,
      '{16'd0, 16'd32768, 16'd32768, 16'd32768}},
    '{'{MODE_HSV, 16'd0, 16'd32768, 16'd0, 16'd100}, 1,
      '{16'd7680, 16'd32768, 16'd32768, 16'd100}},
    '{'{MODE_HSV, 16'd0, 16'd0, 16'd32768, 16'd0}, 1,
      '{16'd15360, 16'd32768, 16'd32768, 16'd0}},
    '{'{MODE_HSV, 16'd32768, 16'd32768, 16'd32768, 16'hffff}, 1,
      '{16'd0, 16'd0, 16'd32768, 16'd32768}},
    '{'{MODE_HSV, 16'hffff, 16'hffff, 16'hffff, 16'd5}, 1,
      '{16'd0, 16'd0, 16'd32768, 16'd5}},
    '{'{MODE_HSV, 16'd32768, 16'd0, 16'd100, 16'd0}, 0, '{default: '0}},
    '{'{MODE_RGB, 16'd1000, 16'd0, 16'd12345, 16'd7}, 1,
      '{16'd12345, 16'd12345, 16'd12345, 16'd7}},
    '{'{MODE_RGB, 16'd0, 16'd32768, 16'd32768, 16'd0}, 1,
      '{16'd32768, 16'd0, 16'd0, 16'd0}},
    '{'{MODE_RGB, 16'd23040, 16'd32768, 16'd32768, 16'd0}, 1,
      '{16'd32768, 16'd0, 16'd0, 16'd0}},
    '{'{MODE_RGB, 16'hffff, 16'hffff, 16'hffff, 16'hffff}, 0, '{default: '0}},
    '{'{MODE_RGB, 16'd23039, 16'd32768, 16'd32768, 16'd1}, 0, '{default: '0}},
    '{'{MODE_RGB, 16'd3840, 16'd16384, 16'd20000, 16'd2}, 0, '{default: '0}},
    '{'{MODE_RGB, 16'd19200, 16'd20000, 16'd30000, 16'd3}, 0, '{default: '0}},
    '{'{MODE_ADJ, 16'd0, 16'd0, 16'd0, 16'd32768}, 1, '{16'd0, 16'd0, 16'd0, 16'd32768}},
    '{'{MODE_ADJ, 16'd32768, 16'd1000, 16'd500, 16'd20000}, 0, '{default: '0}},
    '{'{MODE_ADJ, 16'hffff, 16'hffff, 16'd0, 16'hffff}, 0, '{default: '0}},
    '{'{MODE_PASS, 16'hffff, 16'd40000, 16'd12, 16'hffff}, 1,
      '{16'd32768, 16'd32768, 16'd12, 16'd32768}},
    '{'{MODE_PASS, 16'd1, 16'd2, 16'd3, 16'd4}, 1, '{16'd1, 16'd2, 16'd3, 16'd4}}
  };

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    int pat, run;
    pat = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
        hold_long = 1'b0;
      end
      pat = $urandom_range(0, 3);
      run = $urandom_range(1, 40);
      repeat (run) begin
        case (pat)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 1) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pix_expected_q.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $realtime, out_data_o);
        errors++;
      end else begin
        want = pix_expected_q.pop_front();
        if (want.out_c0 !== out_data_o.out_c0 || want.out_c1 !== out_data_o.out_c1 ||
            want.out_c2 !== out_data_o.out_c2 ||
            want.out_alpha !== out_data_o.out_alpha) begin
          $display("%0t: mismatch expected %0d %0d %0d %0d actual %0d %0d %0d %0d",
                   $realtime, want.out_c0, want.out_c1, want.out_c2, want.out_alpha,
                   out_data_o.out_c0, out_data_o.out_c1, out_data_o.out_c2,
                   out_data_o.out_alpha);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic random_phase(input int n);
    int sent, burst;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < n) begin
          send_pixel(rand_pixel());
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [31:0] hues[4], sats[4], vals[4], gains[4];
    hue_ofs = 0; sat_ofs = 0; val_ofs = 0;
    a_scale = 16'd32768; a_gain = 16'd32768;
    hues  = '{32'hFFFF_A601, 32'd23039, 32'd1234, 32'hFFFF_F000};
    sats  = '{32'h1_8000, 32'h0_8000, 32'h1_F000, 32'd3000};
    vals  = '{32'h0_8000, 32'h1_8000, 32'd2500, 32'h1_F800};
    gains = '{32'd0, 32'd65535, 32'd16384, 32'd40000};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset configuration
    foreach (stim_table[i]) begin
      if (stim_table[i].known) begin
        pix_out_t p;
        p = convert_pixel(stim_table[i].px);
        if (p !== stim_table[i].res)
          $display("%0t: table row %0d disagrees with prediction", $realtime, i);
      end
      send_pixel(stim_table[i].px);
      if (stim_table[i].known) pix_expected_q[$] = stim_table[i].res;
    end
    in_valid_i <= 1'b0;

    // sender pause until every expected result has come
    drain();
    random_phase(300);

    // long receiver hold-off while the sender keeps pushing
    hold_long = 1'b1;
    random_phase(200);
    drain();

    for (int k = 0; k < 4; k++) begin
      reg_write(REG_HUE, hues[k]);
      reg_write(REG_SAT, sats[k]);
      reg_write(REG_VAL, vals[k]);
      reg_write(REG_ASC, gains[k]);
      reg_write(REG_AGN, gains[3 - k]);
      random_phase(300);
      drain();
    end

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
